// File: rtl/core/qasf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qasf_pkg
// Shared constants and types for the quote-aware substring finder.
// ----------------------------------------------------------------------------
package qasf_pkg;

    localparam int MAX_PATTERN_DEF   = 8;
    localparam int POSITION_BITS_DEF = 16;

    localparam int CHAR_W        = 8;
    localparam int PATTERN_BYTES = 8;
    localparam int PATTERN_W     = CHAR_W * PATTERN_BYTES;
    localparam int LEN_W         = 4;
    localparam int OFFSET_W      = 16;
    localparam int CFG_INDEX_W   = 2;
    localparam int CFG_DATA_W    = 64;

    localparam logic [CHAR_W-1:0] CH_QUOTE  = 8'h22;
    localparam logic [CHAR_W-1:0] CH_BSLASH = 8'h5C;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_PATTERN        = 2'd0,
        REG_PATTERN_LENGTH = 2'd1,
        REG_START_OFFSET   = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic [PATTERN_W-1:0] pattern;
        logic [LEN_W-1:0]     eff_len;
        logic [OFFSET_W-1:0]  start_offset;
    } cfg_t;

endpackage

// File: rtl/core/qasf_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qasf_if
// Valid/ready channels: character input, search result output, config write.
// ----------------------------------------------------------------------------
interface qasf_in_if;
    logic                        valid;
    logic                        ready;
    logic [qasf_pkg::CHAR_W-1:0] data_char;
    logic                        last_char;

    modport source (output valid, output data_char, output last_char, input ready);
    modport sink   (input valid, input data_char, input last_char, output ready);
endinterface

interface qasf_out_if #(
    parameter int POSITION_BITS = qasf_pkg::POSITION_BITS_DEF
);
    logic                     valid;
    logic                     ready;
    logic                     found;
    logic [POSITION_BITS-1:0] match_position;

    modport source (output valid, output found, output match_position, input ready);
    modport sink   (input valid, input found, input match_position, output ready);
endinterface

interface qasf_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [qasf_pkg::CFG_INDEX_W-1:0] index;
    logic [qasf_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/core/qasf_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qasf_cfg_regs
// Configuration register file with pattern length clamping.
// ----------------------------------------------------------------------------
module qasf_cfg_regs #(
    parameter int MAX_PATTERN = qasf_pkg::MAX_PATTERN_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    qasf_cfg_if.sink      cfg,
    output qasf_pkg::cfg_t cfg_out
);
    import qasf_pkg::*;

    logic [PATTERN_W-1:0] pattern_reg;
    logic [LEN_W-1:0]     length_reg;
    logic [OFFSET_W-1:0]  offset_reg;
    logic                 wr_en;

    assign cfg.ready = 1'b1;
    assign wr_en     = cfg.valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_reg <= '0;
            length_reg  <= LEN_W'(1);
            offset_reg  <= '0;
        end
        else if (wr_en)
        begin
            unique case (cfg.index)
                REG_PATTERN:        pattern_reg <= cfg.data[PATTERN_W-1:0];
                REG_PATTERN_LENGTH: length_reg  <= cfg.data[LEN_W-1:0];
                REG_START_OFFSET:   offset_reg  <= cfg.data[OFFSET_W-1:0];
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        cfg_out.pattern      = pattern_reg;
        cfg_out.start_offset = offset_reg;
        if (length_reg == '0)
            cfg_out.eff_len = LEN_W'(1);
        else if (length_reg > LEN_W'(MAX_PATTERN))
            cfg_out.eff_len = LEN_W'(MAX_PATTERN);
        else
            cfg_out.eff_len = length_reg;
    end

endmodule

// File: rtl/core/qasf_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qasf_scan
// Per-string scan state (quotes, escape, window) and combinational match check.
// ----------------------------------------------------------------------------
module qasf_scan #(
    parameter int MAX_PATTERN   = qasf_pkg::MAX_PATTERN_DEF,
    parameter int POSITION_BITS = qasf_pkg::POSITION_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          step,
    input  logic [qasf_pkg::CHAR_W-1:0]   data_char,
    input  logic                          last_char,
    input  qasf_pkg::cfg_t                cfg_in,
    output logic                          produce,
    output logic                          found,
    output logic [POSITION_BITS-1:0]      match_position
);
    import qasf_pkg::*;

    localparam int SLOT_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int CMP_W  = (POSITION_BITS > OFFSET_W) ? POSITION_BITS : OFFSET_W;
    localparam logic [POSITION_BITS-1:0] POS_SAT = '1;

    logic [POSITION_BITS-1:0] idx_reg, idx_next;
    logic                     quote_reg, quote_next;
    logic                     skip_reg, skip_next;
    logic [CHAR_W-1:0]        window_reg [MAX_PATTERN];
    logic [CHAR_W-1:0]        window_next [MAX_PATTERN];
    logic [MAX_PATTERN-1:0]   elig_reg, elig_next;
    logic                     reported_reg, reported_next;

    logic                     active;
    logic                     in_range;
    logic                     elig;
    logic                     chars_ok;
    logic                     hit;
    logic [LEN_W-1:0]         lenm1;
    logic [LEN_W-1:0]         sel;

    assign active   = !reported_reg && (idx_reg != POS_SAT);
    assign in_range = CMP_W'(idx_reg) >= CMP_W'(cfg_in.start_offset);
    assign lenm1    = cfg_in.eff_len - LEN_W'(1);

    always_comb
    begin
        quote_next = quote_reg;
        skip_next  = skip_reg;
        elig       = 1'b0;
        if (in_range)
        begin
            if (skip_reg)
                skip_next = 1'b0;
            else if (data_char == CH_QUOTE)
                quote_next = !quote_reg;
            else if (data_char == CH_BSLASH)
                skip_next = 1'b1;
            else if (!quote_reg)
                elig = 1'b1;
        end
    end

    always_comb
    begin
        window_next[0] = data_char;
        elig_next[0]   = elig;
        for (int k = 1; k < MAX_PATTERN; k++)
        begin
            window_next[k] = window_reg[k-1];
            elig_next[k]   = elig_reg[k-1];
        end
    end

    always_comb
    begin
        chars_ok = 1'b1;
        sel      = '0;
        for (int k = 0; k < MAX_PATTERN; k++)
        begin
            sel = lenm1 - LEN_W'(k);
            if ((LEN_W'(k) <= lenm1)
                && (window_next[k] != cfg_in.pattern[{sel[2:0], 3'b000} +: CHAR_W]))
                chars_ok = 1'b0;
        end
    end

    assign hit = active && elig_next[lenm1[SLOT_W-1:0]] && chars_ok;

    assign produce        = hit || (last_char && !reported_reg);
    assign found          = hit;
    assign match_position = hit ? (idx_reg - POSITION_BITS'(lenm1)) : '0;

    assign reported_next  = reported_reg || hit;
    assign idx_next       = idx_reg + POSITION_BITS'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg      <= '0;
            quote_reg    <= 1'b0;
            skip_reg     <= 1'b0;
            elig_reg     <= '0;
            reported_reg <= 1'b0;
            for (int k = 0; k < MAX_PATTERN; k++)
                window_reg[k] <= '0;
        end
        else if (step)
        begin
            if (last_char)
            begin
                idx_reg      <= '0;
                quote_reg    <= 1'b0;
                skip_reg     <= 1'b0;
                elig_reg     <= '0;
                reported_reg <= 1'b0;
                for (int k = 0; k < MAX_PATTERN; k++)
                    window_reg[k] <= '0;
            end
            else if (active)
            begin
                idx_reg      <= idx_next;
                quote_reg    <= quote_next;
                skip_reg     <= skip_next;
                elig_reg     <= elig_next;
                reported_reg <= reported_next;
                for (int k = 0; k < MAX_PATTERN; k++)
                    window_reg[k] <= window_next[k];
            end
        end
    end

endmodule

// File: rtl/core/quote_aware_substring_find_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quote_aware_substring_find_top
// Streams a string one character per transaction and reports the first
// occurrence of the pattern that starts outside double quotes.
// ----------------------------------------------------------------------------
// Usage:
//   cfg      : register writes (pattern, pattern_length, start_offset); always
//              ready; write only while no string is in flight.
//   data_in  : one character per transaction, last_char on the final one.
//   data_out : at most one transaction per string: found = 1 with the index
//              of the first match, or found = 0 at the end of the string.
// Pipeline: input register, then scan/compare into the output register.
// Throughput: one character per cycle unless data_out stalls; the window
//   compare is one parallel check of all pattern slots in the scan stage.
// Stall: when data_out is held off, the output register keeps its result and
//   the input register fills; data_in.ready then drops until data_out moves.
// Reset: clears the pipeline, the scan state and the configuration
//   (pattern 0, pattern_length 1, start_offset 0).
// ----------------------------------------------------------------------------
module quote_aware_substring_find_top #(
    parameter int MAX_PATTERN   = qasf_pkg::MAX_PATTERN_DEF,
    parameter int POSITION_BITS = qasf_pkg::POSITION_BITS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    qasf_cfg_if.sink      cfg,
    qasf_in_if.sink       data_in,
    qasf_out_if.source    data_out
);
    import qasf_pkg::*;

    cfg_t                     cfg_cur;

    logic                     in_valid_reg;
    logic [CHAR_W-1:0]        in_char_reg;
    logic                     in_last_reg;

    logic                     out_valid_reg, out_valid_next;
    logic                     out_found_reg;
    logic [POSITION_BITS-1:0] out_pos_reg;

    logic                     advance;
    logic                     fire;
    logic                     in_take;
    logic                     scan_produce;
    logic                     scan_found;
    logic [POSITION_BITS-1:0] scan_pos;

    qasf_cfg_regs #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .cfg_out (cfg_cur)
    );

    qasf_scan #(
        .MAX_PATTERN   (MAX_PATTERN),
        .POSITION_BITS (POSITION_BITS)
    ) u_scan (
        .clk            (clk),
        .rst_n          (rst_n),
        .step           (fire),
        .data_char      (in_char_reg),
        .last_char      (in_last_reg),
        .cfg_in         (cfg_cur),
        .produce        (scan_produce),
        .found          (scan_found),
        .match_position (scan_pos)
    );

    assign advance       = !out_valid_reg || data_out.ready;
    assign fire          = in_valid_reg && advance;
    assign data_in.ready = !in_valid_reg || advance;
    assign in_take       = data_in.valid && data_in.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_take)
            in_valid_reg <= 1'b1;
        else if (fire)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_char_reg <= data_in.data_char;
            in_last_reg <= data_in.last_char;
        end
    end

    assign out_valid_next = advance ? (fire && scan_produce) : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (fire && scan_produce)
        begin
            out_found_reg <= scan_found;
            out_pos_reg   <= scan_pos;
        end
    end

    assign data_out.valid          = out_valid_reg;
    assign data_out.found          = out_found_reg;
    assign data_out.match_position = out_pos_reg;

`ifndef SYNTHESIS
    a_notfound_pos_zero : assert property (@(posedge clk) disable iff (!rst_n)
        (data_out.valid && !data_out.found) |-> (data_out.match_position == '0))
        else $error("not-found result carries a nonzero position");

    a_stall_holds_input : assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && data_out.valid && !data_out.ready) |=> in_valid_reg)
        else $error("input item dropped while output stalled");

    a_no_take_when_full : assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && data_out.valid && !data_out.ready) |-> !data_in.ready)
        else $error("input accepted with both stages full");
`endif

endmodule

// File: test/quote_aware_substring_find_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quote_aware_substring_find_top_tb
// Streams strings through the quote-aware substring finder and checks every
// search result against an in-bench scan predictor. Covers directed corner
// strings, a long output stall, and random strings under several search
// settings and idle patterns.
// ----------------------------------------------------------------------------
module quote_aware_substring_find_top_tb;
    import qasf_pkg::*;

    localparam int                     POS_W     = POSITION_BITS_DEF;
    localparam logic [POS_W-1:0]       POS_LIMIT = '1;
    localparam int                     WIN_DEPTH = MAX_PATTERN_DEF;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              is_last;
    } char_item_t;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] position;
    } search_result_t;

    logic clk;
    logic rst_n;

    qasf_in_if                             in_bus ();
    qasf_out_if #(.POSITION_BITS(POS_W))   out_bus ();
    qasf_cfg_if                            cfg_bus ();

    quote_aware_substring_find_top #(
        .MAX_PATTERN   (MAX_PATTERN_DEF),
        .POSITION_BITS (POS_W)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_bus),
        .data_in  (in_bus),
        .data_out (out_bus)
    );

    // search settings as last written
    logic [PATTERN_W-1:0] cfg_pattern = '0;
    logic [LEN_W-1:0]     cfg_len     = 4'd1;
    logic [OFFSET_W-1:0]  cfg_offset  = '0;

    // scan state of the current string
    logic [POS_W-1:0]     scan_index;
    logic                 in_quotes;
    logic                 escape_next;
    logic [CHAR_W-1:0]    char_window [WIN_DEPTH];
    logic [WIN_DEPTH-1:0] start_ok;
    logic                 reported;

    char_item_t     char_q [$];
    search_result_t expected_results [$];
    char_item_t     drv_item;
    search_result_t want;

    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    logic        hold_request  = 1'b0;
    int unsigned hold_cycles;
    int unsigned mismatch_count = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        rst_n             = 1'b0;
        in_bus.valid      = 1'b0;
        in_bus.data_char  = '0;
        in_bus.last_char  = 1'b0;
        out_bus.ready     = 1'b0;
        cfg_bus.valid     = 1'b0;
        cfg_bus.index     = '0;
        cfg_bus.data      = '0;
        clear_scan();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        #20_000_000;
        $display("quote_aware_substring_find_top_tb: FAIL");
        $finish;
    end

    function automatic void clear_scan();
        scan_index  = '0;
        in_quotes   = 1'b0;
        escape_next = 1'b0;
        for (int k = 0; k < WIN_DEPTH; k++)
            char_window[k] = '0;
        start_ok = '0;
        reported = 1'b0;
    endfunction

    function automatic int eff_len();
        if (cfg_len == 0)
            return 1;
        if (cfg_len > WIN_DEPTH)
            return WIN_DEPTH;
        return int'(cfg_len);
    endfunction

    function automatic void scan_char(logic [CHAR_W-1:0] ch, logic is_last);
        logic elig;
        logic hit;
        int   len;
        len = eff_len();
        if (!reported && scan_index != POS_LIMIT)
        begin
            elig = 1'b0;
            if (scan_index >= cfg_offset)
            begin
                if (escape_next)
                    escape_next = 1'b0;
                else if (ch == CH_QUOTE)
                    in_quotes = !in_quotes;
                else if (ch == CH_BSLASH)
                    escape_next = 1'b1;
                else if (!in_quotes)
                    elig = 1'b1;
            end
            for (int k = WIN_DEPTH - 1; k > 0; k--)
                char_window[k] = char_window[k-1];
            char_window[0] = ch;
            start_ok = {start_ok[WIN_DEPTH-2:0], elig};
            if (start_ok[len-1])
            begin
                hit = 1'b1;
                for (int j = 0; j < len; j++)
                    if (char_window[len-1-j] != cfg_pattern[8*j +: 8])
                        hit = 1'b0;
                if (hit)
                begin
                    expected_results.push_back('{1'b1, POS_W'(scan_index - (len - 1))});
                    reported = 1'b1;
                end
            end
            scan_index = scan_index + 1'b1;
        end
        if (is_last)
        begin
            if (!reported)
                expected_results.push_back('{1'b0, '0});
            clear_scan();
        end
    endfunction

    task automatic report_mismatch(string msg);
        if (mismatch_count < 40)
            $display("ERROR @%0t: %s", $time, msg);
        mismatch_count++;
    endtask

    // character driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_bus.valid     <= 1'b0;
            in_bus.data_char <= '0;
            in_bus.last_char <= 1'b0;
        end
        else
        begin
            if (in_bus.valid && in_bus.ready)
                scan_char(in_bus.data_char, in_bus.last_char);
            if (!in_bus.valid || in_bus.ready)
            begin
                if (char_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    drv_item = char_q.pop_front();
                    in_bus.valid     <= 1'b1;
                    in_bus.data_char <= drv_item.ch;
                    in_bus.last_char <= drv_item.is_last;
                end
                else
                begin
                    in_bus.valid <= 1'b0;
                end
            end
        end
    end

    // long output hold-off
    always @(posedge clk)
    begin
        if (!rst_n)
            hold_cycles <= 0;
        else if (hold_request)
            hold_cycles <= 300;
        else if (hold_cycles != 0)
            hold_cycles <= hold_cycles - 1;
    end

    // result monitor
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_bus.ready <= 1'b0;
        end
        else
        begin
            if (out_bus.valid && out_bus.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected transaction found=%0b pos=%0d",
                                              out_bus.found, out_bus.match_position));
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (out_bus.found !== want.found)
                        report_mismatch($sformatf("found %0b, expected %0b",
                                                  out_bus.found, want.found));
                    if (out_bus.match_position !== want.position)
                        report_mismatch($sformatf("match_position %0d, expected %0d",
                                                  out_bus.match_position, want.position));
                end
            end
            out_bus.ready <= (hold_cycles == 0) && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic write_reg(cfg_reg_t which, logic [CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= which;
        cfg_bus.data  <= value;
        do
            @(posedge clk);
        while (cfg_bus.ready !== 1'b1);
        cfg_bus.valid <= 1'b0;
        case (which)
            REG_PATTERN:        cfg_pattern = value;
            REG_PATTERN_LENGTH: cfg_len     = value[LEN_W-1:0];
            REG_START_OFFSET:   cfg_offset  = value[OFFSET_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_search(logic [PATTERN_W-1:0] pat, logic [LEN_W-1:0] len,
                              logic [OFFSET_W-1:0] offset);
        write_reg(REG_PATTERN, pat);
        write_reg(REG_PATTERN_LENGTH, CFG_DATA_W'(len));
        write_reg(REG_START_OFFSET, CFG_DATA_W'(offset));
    endtask

    task automatic set_idling(int unsigned send_pct, int unsigned recv_pct);
        @(posedge clk);
        send_idle_pct <= send_pct;
        recv_idle_pct <= recv_pct;
    endtask

    task automatic wait_idle();
        @(negedge clk);
        while (char_q.size() != 0 || in_bus.valid || expected_results.size() != 0)
            @(negedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic queue_text(string s);
        @(negedge clk);
        for (int i = 0; i < s.len(); i++)
            char_q.push_back('{s[i], i == s.len() - 1});
    endtask

    function automatic logic [CHAR_W-1:0] rand_char();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 20)
            return "a";
        if (r < 40)
            return "b";
        if (r < 52)
            return CH_QUOTE;
        if (r < 62)
            return CH_BSLASH;
        return CHAR_W'($urandom_range(255));
    endfunction

    task automatic queue_random_strings(int unsigned n);
        logic [CHAR_W-1:0] text [$];
        int unsigned       total;
        int unsigned       slen;
        int unsigned       p;
        int                len;
        total = 0;
        len   = eff_len();
        @(negedge clk);
        while (total < n)
        begin
            text.delete();
            slen = ($urandom_range(9) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 16);
            for (int i = 0; i < slen; i++)
                if ($urandom_range(99) < 30)
                    text.push_back(cfg_pattern[8*$urandom_range(len-1) +: 8]);
                else
                    text.push_back(rand_char());
            if ($urandom_range(1))
            begin
                p = $urandom_range(slen - 1);
                for (int j = 0; j < len && p + j < slen; j++)
                    text[p+j] = cfg_pattern[8*j +: 8];
            end
            for (int i = 0; i < slen; i++)
                char_q.push_back('{text[i], i == slen - 1});
            total += slen;
        end
    endtask

    initial
    begin
        logic [PATTERN_W-1:0] pat;
        logic [LEN_W-1:0]     len;
        logic [OFFSET_W-1:0]  offset;

        wait (rst_n === 1'b1);
        set_idling(30, 52);

        // reset settings: pattern 0, length 1, offset 0
        @(negedge clk);
        char_q.push_back('{8'h00, 1'b1});
        wait_idle();
        set_search('1, 4'd1, 16'd0);
        @(negedge clk);
        char_q.push_back('{8'hFF, 1'b1});
        wait_idle();

        set_search(64'h6261, 4'd2, 16'd0);
        queue_text("xab");
        queue_text("\"ab\"ab");
        queue_text("\\ab");
        queue_text("a");
        wait_idle();

        set_search(64'h6261, 4'd2, 16'd2);
        queue_text("abab");
        queue_text("\"xab");
        wait_idle();

        write_reg(REG_PATTERN_LENGTH, CFG_DATA_W'(0));
        queue_text("ba");
        wait_idle();
        write_reg(REG_PATTERN_LENGTH, CFG_DATA_W'(15));
        queue_text("ab");
        wait_idle();
        set_search(64'h6261, 4'd2, 16'hFFFF);
        queue_text("ab");
        wait_idle();

        // output held off while single-character strings keep coming
        set_search(64'h61, 4'd1, 16'd0);
        set_idling(0, 52);
        @(posedge clk);
        hold_request <= 1'b1;
        @(posedge clk);
        hold_request <= 1'b0;
        for (int i = 0; i < 60; i++)
            queue_text("a");
        wait_idle();

        for (int mode = 0; mode < 3; mode++)
        begin
            case (mode)
                0:       set_idling(30, 52);
                1:       set_idling(52, 30);
                default: set_idling(0, 0);
            endcase
            for (int s = 0; s < 6; s++)
            begin
                for (int j = 0; j < PATTERN_BYTES; j++)
                    pat[8*j +: 8] = rand_char();
                case (s)
                    0:       len = 4'd8;
                    1:       len = 4'd1;
                    2:       len = $urandom_range(1) ? 4'd0 : LEN_W'($urandom_range(9, 15));
                    default: len = LEN_W'($urandom_range(1, 8));
                endcase
                offset = (s == 3) ? OFFSET_W'($urandom_range(10, 30))
                                  : OFFSET_W'($urandom_range(0, 3));
                set_search(pat, len, offset);
                queue_random_strings(85);
                wait_idle();
            end
        end

        if (mismatch_count == 0)
            $display("quote_aware_substring_find_top_tb: PASS");
        else
            $display("quote_aware_substring_find_top_tb: FAIL");
        $finish;
    end

endmodule
